[sv/sidta_pkg.sv]
package sidta_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int DIGIT_BITS = 4;
   localparam int CHAR_BITS = 8;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'd45;

   // decimal digits of the largest magnitude 2^(bits-1)
   function automatic int digit_count(input int bits);
      return ((bits - 1) * 30103) / 100000 + 1;
   endfunction

   typedef struct packed {
      logic clear;
      logic bit_shift;
      logic digit_shift;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_SKIP,
      ST_EMIT
   } state_type;

endpackage

[sv/signed_int_to_decimal_ascii.sv]
// signed integer to decimal ascii text
//
// input channel: req_valid / req_stall carries one two's complement
// req_value per beat. result channel: rsp_valid / rsp_stall carries one
// ascii character per beat, '-' first for a negative value, then the
// digits most significant first with no leading zeros; rsp_last marks the
// final character of a value.
//
// one value at a time: req_stall is high from the accept until the last
// character is loaded into the output register. after the accept, a value
// goes through one shift-add-3 step per input bit in the chain of bcd
// digit cells, a sign step that loads a minus for a negative value, a skip
// of the leading zero digits, and then the digits sent one by one. skipped
// zeros and digits always add up to the cell count.
//
// a stall on the result side holds the output register and the chain;
// the next value may be accepted while the last character still waits.
// reset returns to idle and drops rsp_valid; no state is kept between values.
module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = sidta_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [VALUE_BITS-1:0]      req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sidta_pkg::CHAR_BITS-1:0]   rsp_character,
   output logic                              rsp_last
);

   localparam int NDIG  = sidta_pkg::digit_count(VALUE_BITS);
   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam int REM_W = $clog2(NDIG + 1);
   localparam int DW    = sidta_pkg::DIGIT_BITS;

   sidta_pkg::state_type state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [sidta_pkg::CHAR_BITS-1:0] rsp_character_ff, rsp_character_in;
   logic                  rsp_last_ff, rsp_last_in;

   sidta_pkg::cell_ctrl_type ctrl;
   logic [VALUE_BITS-1:0] raw;
   logic                  out_free;
   logic [DW-1:0]         top_digit;

   logic [NDIG-1:0]       carry;
   logic [DW-1:0]         digits [NDIG];
   logic [DW-1:0]         low_digits [NDIG];

   assign carry[0]      = mag_ff[VALUE_BITS-1];
   assign low_digits[0] = '0;
   assign top_digit     = digits[NDIG-1];

   genvar g;
   generate
      for (g = 0; g < NDIG; g++) begin : g_cell
         if (g > 0) begin : g_link
            assign low_digits[g] = digits[g-1];
         end
         if (g < NDIG - 1) begin : g_mid
            sidta_bcd_cell u_cell (
               .clock     (clock),
               .ctrl      (ctrl),
               .low_bit   (carry[g]),
               .low_digit (low_digits[g]),
               .high_bit  (carry[g+1]),
               .digit     (digits[g])
            );
         end else begin : g_top
            // magnitude always fits, the top carry is never set
            sidta_bcd_cell u_cell (
               .clock     (clock),
               .ctrl      (ctrl),
               .low_bit   (carry[g]),
               .low_digit (low_digits[g]),
               .high_bit  (),
               .digit     (digits[g])
            );
         end
      end
   endgenerate

   assign raw      = req_value;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in         = state_ff;
      mag_in           = mag_ff;
      neg_in           = neg_ff;
      cnt_in           = cnt_ff;
      rem_in           = rem_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      ctrl             = '0;
      case (state_ff)
         sidta_pkg::ST_IDLE: begin
            if (req_valid) begin
               neg_in   = raw[VALUE_BITS-1];
               mag_in   = raw[VALUE_BITS-1] ?
                          (~raw) + {{(VALUE_BITS-1){1'b0}}, 1'b1} : raw;
               cnt_in   = CNT_W'(VALUE_BITS);
               rem_in   = REM_W'(NDIG);
               ctrl.clear = 1'b1;
               state_in = sidta_pkg::ST_CONVERT;
            end
         end
         sidta_pkg::ST_CONVERT: begin
            ctrl.bit_shift = 1'b1;
            mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = sidta_pkg::ST_SIGN;
            end
         end
         sidta_pkg::ST_SIGN: begin
            if (!neg_ff) begin
               state_in = sidta_pkg::ST_SKIP;
            end else if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = sidta_pkg::CHAR_MINUS;
               rsp_last_in      = 1'b0;
               state_in         = sidta_pkg::ST_SKIP;
            end
         end
         sidta_pkg::ST_SKIP: begin
            if (top_digit == '0 && rem_ff > REM_W'(1)) begin
               ctrl.digit_shift = 1'b1;
               rem_in = rem_ff - 1'b1;
            end else begin
               state_in = sidta_pkg::ST_EMIT;
            end
         end
         sidta_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = sidta_pkg::CHAR_ZERO + {4'b0000, top_digit};
               rsp_last_in      = (rem_ff == REM_W'(1));
               ctrl.digit_shift = 1'b1;
               rem_in           = rem_ff - 1'b1;
               if (rem_ff == REM_W'(1)) begin
                  state_in = sidta_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sidta_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sidta_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      neg_ff           <= neg_in;
      cnt_ff           <= cnt_in;
      rem_ff           <= rem_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign req_stall     = (state_ff != sidta_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

[sv/sidta_bcd_cell.sv]
module sidta_bcd_cell (
   input  logic                                clock,
   input  sidta_pkg::cell_ctrl_type            ctrl,
   input  logic                                low_bit,
   input  logic [sidta_pkg::DIGIT_BITS-1:0]    low_digit,
   output logic                                high_bit,
   output logic [sidta_pkg::DIGIT_BITS-1:0]    digit
);

   logic [sidta_pkg::DIGIT_BITS-1:0] digit_ff;
   logic [sidta_pkg::DIGIT_BITS-1:0] digit_in;
   logic [sidta_pkg::DIGIT_BITS-1:0] adjusted;

   // add 3 before the shift so the digit carries at ten
   always_comb begin
      adjusted = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
      high_bit = adjusted[3];
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.bit_shift) begin
         digit_in = {adjusted[2:0], low_bit};
      end else if (ctrl.digit_shift) begin
         digit_in = low_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

[sv/sidta_chk.sv]
module sidta_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [sidta_pkg::CHAR_BITS-1:0]   rsp_character,
   input logic                              rsp_last
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // only a minus sign or a decimal digit leaves the block
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == sidta_pkg::CHAR_MINUS) ||
                    (rsp_character >= sidta_pkg::CHAR_ZERO &&
                     rsp_character <= sidta_pkg::CHAR_ZERO + 8'd9))
      else $error("result character out of range");

   // a minus sign is never marked as the last character
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == sidta_pkg::CHAR_MINUS |-> !rsp_last)
      else $error("minus sign marked last");

   // busy right after taking a value
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second value taken during conversion");

   // reset empties the output register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind signed_int_to_decimal_ascii sidta_chk u_sidta_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);

[bench/signed_int_to_decimal_ascii_tb.sv]
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

   localparam int VALUE_BITS = 32;
   localparam int DECIMAL_BASE = 10;
   localparam int MAX_DIGITS = 10;
   localparam int RANDOM_VALUES = 138;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int IDLE_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic [sidta_pkg::CHAR_BITS-1:0] character;
      logic                            last;
   } text_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [VALUE_BITS-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [sidta_pkg::CHAR_BITS-1:0] rsp_character;
   logic rsp_last;

   logic signed [VALUE_BITS-1:0] pending_values[$];
   text_beat_type expected_text[$];
   int errors = 0;
   int values_accepted = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int stall_mode = 0;
   int stall_count = 0;
   int idle_cycles = 0;

   signed_int_to_decimal_ascii #(
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_character(rsp_character),
      .rsp_last(rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // decimal text of one value, sign first, then digits most significant first
   function automatic void predict_text(input logic signed [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] magnitude;
      logic [sidta_pkg::CHAR_BITS-1:0] digits[MAX_DIGITS];
      int count;
      int k;
      text_beat_type beat;
      magnitude = value;
      if (value[VALUE_BITS-1]) begin
         magnitude = ~magnitude + 1'b1;
      end
      count = 0;
      do begin
         digits[count] = sidta_pkg::CHAR_ZERO +
                         sidta_pkg::CHAR_BITS'(magnitude % DECIMAL_BASE);
         magnitude = magnitude / DECIMAL_BASE;
         count++;
      end while (magnitude != 0);
      if (value[VALUE_BITS-1]) begin
         beat.character = sidta_pkg::CHAR_MINUS;
         beat.last = 1'b0;
         expected_text.push_back(beat);
      end
      for (k = count - 1; k >= 0; k--) begin
         beat.character = digits[k];
         beat.last = (k == 0);
         expected_text.push_back(beat);
      end
   endfunction

   // sender: bursts of beats with random gaps
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            predict_text(req_value);
            void'(pending_values.pop_front());
            values_accepted++;
            next_valid = 1'b0;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               next_valid = 1'b0;
            end else if (pending_values.size() > 0) begin
               next_valid = 1'b1;
               req_value <= pending_values[0];
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end else begin
               next_valid = 1'b0;
            end
         end
         req_valid <= next_valid;
      end
   end

   // receiver: changing stall pattern plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && values_accepted >= 40) begin
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count % 80 == 79) begin
            stall_mode <= $urandom_range(0, 3);
         end
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= (stall_count % 5 < 2);
            end
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      text_beat_type beat;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_text.size() == 0) begin
            $error("unexpected beat: character %0d last %0b", rsp_character, rsp_last);
            errors++;
         end else begin
            beat = expected_text.pop_front();
            if (rsp_character !== beat.character) begin
               $error("character: expected %0d, actual %0d", beat.character, rsp_character);
               errors++;
            end
            if (rsp_last !== beat.last) begin
               $error("last: expected %0b, actual %0b", beat.last, rsp_last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int n;
      int nd;
      longint lo;
      longint hi;
      logic signed [VALUE_BITS-1:0] v;
      pending_values = '{
         32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
         -32'sd5, 32'sd2147483647, -32'sd2147483647, 32'h8000_0000,
         32'sd1000000000, 32'sd999999999, -32'sd999999999, 32'sd1000000009,
         32'sd123456789, -32'sd1234567890, 32'h5555_5555, 32'hAAAA_AAAA,
         -32'sd100, 32'sd10203
      };
      for (n = 0; n < RANDOM_VALUES; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            v = $urandom();
         end else begin
            nd = $urandom_range(1, MAX_DIGITS);
            lo = 1;
            repeat (nd - 1) lo = lo * DECIMAL_BASE;
            hi = lo * DECIMAL_BASE - 1;
            if (nd == 1) begin
               lo = 0;
            end
            if (hi > 64'sd2147483647) begin
               hi = 64'sd2147483647;
            end
            v = $urandom_range(int'(hi), int'(lo));
            if ($urandom_range(0, 1) == 1) begin
               v = -v;
            end
         end
         pending_values.push_back(v);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_values.size() != 0 || req_valid || expected_text.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_text.size() != 0) begin
         $error("%0d expected beats never arrived", expected_text.size());
         errors++;
      end
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
